/* sv/pac_pkg.sv */
`default_nettype none

package pac_pkg;

    localparam int DIV_STG  = 16;
    localparam int LANE_STG = DIV_STG + 1;
    localparam int PIPE_STG = LANE_STG + 2;
    localparam int N_LANES  = 3;

    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_GREY_MODE = 1'b1;

    localparam logic DIR_UNPREMUL = 1'b0;
    localparam logic DIR_PREMUL   = 1'b1;

    localparam logic [15:0] FULL8  = 16'h00FF;
    localparam logic [15:0] FULL16 = 16'hFFFF;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic direction;
        logic grey_mode;
    } t_cfg;

    typedef struct packed {
        t_byte b3;
        t_byte b2;
        t_byte b1;
        t_byte b0;
    } t_pix;

    typedef struct packed {
        logic [15:0] c;
        logic [15:0] a;
    } t_lane_op;

    typedef struct packed {
        logic [15:0] res;
        logic        clip;
    } t_lane_res;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] lo;
        logic [15:0] q;
        logic [15:0] a;
        logic        sat;
        logic        zero;
    } t_div;

    typedef struct packed {
        t_pix bytes;
        logic clipped;
    } t_out;

endpackage

`default_nettype wire

/* sv/pac_if.sv */
`default_nettype none

interface pac_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte0;
    logic [7:0] in_byte1;
    logic [7:0] in_byte2;
    logic [7:0] in_byte3;

    modport source(output valid, output in_byte0, output in_byte1, output in_byte2,
                   output in_byte3, input ready);
    modport sink(input valid, input in_byte0, input in_byte1, input in_byte2,
                 input in_byte3, output ready);
endinterface

interface pac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic       clipped;

    modport source(output valid, output out_byte0, output out_byte1, output out_byte2,
                   output out_byte3, output clipped, input ready);
    modport sink(input valid, input out_byte0, input out_byte1, input out_byte2,
                 input out_byte3, input clipped, output ready);
endinterface

`default_nettype wire

/* sv/premultiplied_alpha_converter_top.sv */
`default_nettype none

// channel   dir  handshake      payload
// i_pix     in   valid/ready    in_byte0..in_byte3
// o_pix     out  valid/ready    out_byte0..out_byte3, clipped
// cfg       in   i_cfg_we       i_cfg_idx (0 direction, 1 grey_mode), i_cfg_data
//
// One pixel per cycle while o_pix is not stalled; input register, 17 lane stages
// (operand prep/multiply, then a 16-stage restoring divider), output register.
// Synchronous active-low reset clears config and valid bits.
// A stall on o_pix holds the whole pipe; a one-beat skid on i_pix keeps i_pix.ready registered.

module premultiplied_alpha_converter_top import pac_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_idx,
    input  wire logic i_cfg_data,
    pac_in_if.sink    i_pix,
    pac_out_if.source o_pix
);

    t_cfg                r_cfg;
    logic                r_skid_vld;
    t_pix                r_skid;
    t_pix                w_in;
    t_pix                w_src;
    logic                w_src_vld;
    logic                w_acc;
    logic                w_en;
    t_pix                r_s0;
    t_pix                r_bd [0:LANE_STG-1];
    logic [PIPE_STG-1:0] r_vld;
    t_lane_op            w_op  [N_LANES];
    t_lane_res           w_res [N_LANES];
    t_out                w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIRECTION: r_cfg.direction <= i_cfg_data;
                CFG_GREY_MODE: r_cfg.grey_mode <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign w_in.b0   = i_pix.in_byte0;
    assign w_in.b1   = i_pix.in_byte1;
    assign w_in.b2   = i_pix.in_byte2;
    assign w_in.b3   = i_pix.in_byte3;
    assign w_acc     = i_pix.valid && i_pix.ready;
    assign w_en      = o_pix.ready || !r_vld[PIPE_STG-1];
    assign w_src_vld = r_skid_vld || w_acc;
    assign w_src     = r_skid_vld ? r_skid : w_in;
    assign i_pix.ready = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
            r_vld      <= '0;
        end else begin
            if (w_acc && !w_en) begin
                r_skid_vld <= 1'b1;
            end else if (w_en) begin
                r_skid_vld <= 1'b0;
            end
            if (w_en) begin
                r_vld <= {r_vld[PIPE_STG-2:0], w_src_vld};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_en) begin
            r_skid <= w_in;
        end
        if (w_en) begin
            r_s0    <= w_src;
            r_bd[0] <= r_s0;
            for (int k = 1; k < LANE_STG; k++) begin
                r_bd[k] <= r_bd[k-1];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < N_LANES; k++) begin
            w_op[k].a = {8'h0, r_s0.b3};
        end
        w_op[0].c = {8'h0, r_s0.b0};
        w_op[1].c = {8'h0, r_s0.b1};
        w_op[2].c = {8'h0, r_s0.b2};
        if (r_cfg.grey_mode) begin
            if (r_cfg.direction == DIR_UNPREMUL) begin
                w_op[0].c = {r_s0.b1, r_s0.b2};
                w_op[0].a = {r_s0.b3, r_s0.b0};
            end else begin
                w_op[0].c = {r_s0.b0, r_s0.b1};
                w_op[0].a = {r_s0.b2, r_s0.b3};
            end
        end
    end

    for (genvar k = 0; k < N_LANES; k++) begin : g_lane
        pac_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_cfg (r_cfg),
            .i_op  (w_op[k]),
            .o_res (w_res[k])
        );
    end

    pac_merge u_merge (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cfg (r_cfg),
        .i_res (w_res),
        .i_pix (r_bd[LANE_STG-1]),
        .o_out (w_out)
    );

    assign o_pix.valid     = r_vld[PIPE_STG-1];
    assign o_pix.out_byte0 = w_out.bytes.b0;
    assign o_pix.out_byte1 = w_out.bytes.b1;
    assign o_pix.out_byte2 = w_out.bytes.b2;
    assign o_pix.out_byte3 = w_out.bytes.b3;
    assign o_pix.clipped   = w_out.clipped;

endmodule

`default_nettype wire

/* sv/pac_lane.sv */
`default_nettype none

module pac_lane import pac_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  wire t_cfg      i_cfg,
    input  wire t_lane_op  i_op,
    output t_lane_res      o_res
);

    logic        w_unpre;
    logic [31:0] w_c32;
    logic [31:0] w_prod;
    logic [31:0] w_num;
    logic [15:0] w_full;
    t_div        n_st [0:DIV_STG];
    t_div        r_st [0:DIV_STG];

    assign w_unpre = (i_cfg.direction == DIR_UNPREMUL);
    assign w_c32   = {16'h0, i_op.c};
    assign w_prod  = w_c32 * {16'h0, i_op.a};

    always_comb begin
        if (w_unpre) begin
            w_num = i_cfg.grey_mode ? ((w_c32 << 16) - w_c32) : ((w_c32 << 8) - w_c32);
        end else begin
            w_num = w_prod;
        end
        n_st[0].rem  = w_num[31:16];
        n_st[0].lo   = w_num[15:0];
        n_st[0].q    = '0;
        n_st[0].a    = i_op.a;
        n_st[0].sat  = (i_op.c > i_op.a);
        n_st[0].zero = (i_op.a == 16'h0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st[0];
        end
    end

    // restoring divide, one quotient bit per stage; premultiply divides by 2^W-1 in stage 0
    for (genvar i = 0; i < DIV_STG; i++) begin : g_div
        logic [16:0] w_t;
        logic [16:0] w_diff;
        logic        w_ge;
        logic [32:0] w_y;
        logic [33:0] w_sg;
        logic [33:0] w_sc;

        assign w_t    = {r_st[i].rem, r_st[i].lo[15]};
        assign w_ge   = (w_t >= {1'b0, r_st[i].a});
        assign w_diff = w_t - {1'b0, r_st[i].a};
        assign w_y    = {1'b0, r_st[i].rem, r_st[i].lo} + 33'd1;
        assign w_sg   = {1'b0, w_y} + {17'h0, w_y[32:16]};
        assign w_sc   = {1'b0, w_y} + {9'h0, w_y[32:8]};

        always_comb begin
            n_st[i+1] = r_st[i];
            if (w_unpre) begin
                n_st[i+1].rem = w_ge ? w_diff[15:0] : w_t[15:0];
                n_st[i+1].lo  = {r_st[i].lo[14:0], 1'b0};
                n_st[i+1].q   = {r_st[i].q[14:0], w_ge};
            end else if (i == 0) begin
                n_st[i+1].q = i_cfg.grey_mode ? w_sg[31:16] : w_sc[23:8];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[i+1] <= n_st[i+1];
            end
        end
    end

    assign w_full = i_cfg.grey_mode ? FULL16 : FULL8;

    always_comb begin
        if (r_st[DIV_STG].zero) begin
            o_res.res = '0;
        end else if (w_unpre && r_st[DIV_STG].sat) begin
            o_res.res = w_full;
        end else begin
            o_res.res = r_st[DIV_STG].q;
        end
        o_res.clip = w_unpre && !r_st[DIV_STG].zero && r_st[DIV_STG].sat;
    end

endmodule

`default_nettype wire

/* sv/pac_merge.sv */
`default_nettype none

module pac_merge import pac_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  wire t_cfg      i_cfg,
    input  wire t_lane_res i_res [N_LANES],
    input  wire t_pix      i_pix,
    output t_out           o_out
);

    t_out n_out;
    t_out r_out;

    always_comb begin
        n_out = '0;
        if (!i_cfg.grey_mode) begin
            n_out.bytes.b0 = i_res[0].res[7:0];
            n_out.bytes.b1 = i_res[1].res[7:0];
            n_out.bytes.b2 = i_res[2].res[7:0];
            n_out.bytes.b3 = i_pix.b3;
            n_out.clipped  = i_res[0].clip | i_res[1].clip | i_res[2].clip;
        end else if (i_cfg.direction == DIR_UNPREMUL) begin
            n_out.bytes.b0 = i_res[0].res[15:8];
            n_out.bytes.b1 = i_res[0].res[7:0];
            n_out.bytes.b2 = i_pix.b3;
            n_out.bytes.b3 = i_pix.b0;
            n_out.clipped  = i_res[0].clip;
        end else begin
            n_out.bytes.b0 = i_pix.b3;
            n_out.bytes.b1 = i_res[0].res[15:8];
            n_out.bytes.b2 = i_res[0].res[7:0];
            n_out.bytes.b3 = i_pix.b2;
            n_out.clipped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire
